// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that must hold on the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/blr_pkg.sv -----
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blr_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef struct packed {
    logic fire;
    op_e  op;
  } blr_cmd_t;

  typedef struct packed {
    logic has_result;
    logic last;
    logic busy;
  } blr_stat_t;

endpackage

// ----- hw/rtl/bresenham_line_rasterizer_unit.sv -----
// A result is registered in the output stage after its input beat has been held in the input stage.
// The unit accepts one input beat per cycle while a held result does not stall the output stage.
// The rate is set by the combinational tick update in blr_core.
// Reset clears the line state to idle and empties the input and output stages.
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// Bresenham line generator with an input stage and a registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bresenham_line_rasterizer_unit import blr_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_point_o
);

  logic                  in_valid_q, in_valid_d;
  op_e                   op_q;
  logic [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic                  last_q;

  logic                  in_take, advance, out_load;
  blr_cmd_t              cmd;
  blr_stat_t             stat;
  logic [COORD_BITS-1:0] core_px, core_py;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i || !stat.has_result);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;
  assign out_load   = advance && stat.has_result;

  assign cmd.fire = advance;
  assign cmd.op   = op_q;

  blr_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .start_x_i(sx_q),
    .start_y_i(sy_q),
    .end_x_i  (ex_q),
    .end_y_i  (ey_q),
    .pixel_x_o(core_px),
    .pixel_y_o(core_py),
    .stat_o   (stat)
  );

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q <= op_e'(opcode_i);
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
    end
    if (out_load) begin
      px_q   <= core_px;
      py_q   <= core_py;
      last_q <= stat.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign last_point_o = last_q;

  `ASSERT_NEXT(a_last_idles, clk_i, rst_ni, out_load && stat.last, !stat.busy, "busy after last")
  `ASSERT_NEXT(a_mid_busy, clk_i, rst_ni, out_load && !stat.last, stat.busy, "idle before last")
  `ASSERT_CLK(a_empty_ready, clk_i, rst_ni, !in_valid_q |-> in_ready_o, "empty input stage not ready")

endmodule

// ----- hw/rtl/blr_core.sv -----
// ----------------------------------------------------------------------------
// blr_core
// Line state and one-step datapath: endpoint setup on start, one pixel per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blr_core import blr_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  blr_cmd_t              cmd_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output blr_stat_t             stat_o
);

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned SW = COORD_BITS + 2;
  localparam int unsigned DW = COORD_BITS + 3;

  logic          busy_q, busy_d;
  logic          steep_q, steep_d;
  logic [W-1:0]  maj_q, maj_d;
  logic [W-1:0]  end_q, end_d;
  logic [W-1:0]  min_q, min_d;
  logic [DW-1:0] dec_q, dec_d;
  logic [SW-1:0] straight_q, straight_d;
  logic [SW-1:0] diag_q, diag_d;
  logic          down_q, down_d;

  logic [W:0]    sx, sy, smaj, smin;
  logic [W-1:0]  adx, ady, dmaj, dmin;
  logic          steep, ord_swap, minor_down;
  logic [W-1:0]  maj_a, maj_b, min_a, min_b, ma, mb, na;
  logic          is_start, dec_le0, last;
  logic [W-1:0]  maj_t, min_t, emit_maj, emit_min, emit_end;
  logic [DW-1:0] dec_t;
  logic          emit_steep;

  assign is_start = (cmd_i.op == OP_START);

  assign sx  = {start_x_i[W-1], start_x_i} - {end_x_i[W-1], end_x_i};
  assign sy  = {start_y_i[W-1], start_y_i} - {end_y_i[W-1], end_y_i};
  assign adx = sx[W] ? W'(-sx) : sx[W-1:0];
  assign ady = sy[W] ? W'(-sy) : sy[W-1:0];

  assign steep = (ady > adx);
  assign smaj  = steep ? sy : sx;
  assign smin  = steep ? sx : sy;
  assign dmaj  = steep ? ady : adx;
  assign dmin  = steep ? adx : ady;

  assign maj_a = steep ? start_y_i : start_x_i;
  assign maj_b = steep ? end_y_i : end_x_i;
  assign min_a = steep ? start_x_i : start_y_i;
  assign min_b = steep ? end_x_i : end_y_i;

  // The endpoints are swapped when the first major coordinate is the larger.
  assign ord_swap   = !smaj[W] && (smaj != '0);
  assign ma         = ord_swap ? maj_b : maj_a;
  assign mb         = ord_swap ? maj_a : maj_b;
  assign na         = ord_swap ? min_b : min_a;
  assign minor_down = ord_swap ? (smin[W] || (smin == '0)) : !smin[W];

  assign dec_le0 = dec_q[DW-1] || (dec_q == '0);
  assign maj_t   = maj_q + W'(1);
  assign min_t   = dec_le0 ? min_q : (down_q ? min_q - W'(1) : min_q + W'(1));
  assign dec_t   = dec_le0 ? dec_q + {straight_q[SW-1], straight_q}
                           : dec_q + {diag_q[SW-1], diag_q};

  assign emit_maj   = is_start ? ma : maj_t;
  assign emit_min   = is_start ? na : min_t;
  assign emit_end   = is_start ? mb : end_q;
  assign emit_steep = is_start ? steep : steep_q;
  assign last       = (emit_maj == emit_end);

  assign pixel_x_o = emit_steep ? emit_min : emit_maj;
  assign pixel_y_o = emit_steep ? emit_maj : emit_min;

  assign stat_o.has_result = is_start || busy_q;
  assign stat_o.last       = last;
  assign stat_o.busy       = busy_q;

  always_comb begin
    busy_d     = busy_q;
    steep_d    = steep_q;
    maj_d      = maj_q;
    end_d      = end_q;
    min_d      = min_q;
    dec_d      = dec_q;
    straight_d = straight_q;
    diag_d     = diag_q;
    down_d     = down_q;
    if (cmd_i.fire && is_start) begin
      busy_d     = !last;
      steep_d    = steep;
      maj_d      = ma;
      end_d      = mb;
      min_d      = na;
      dec_d      = {2'b00, dmin, 1'b0} - {3'b000, dmaj};
      straight_d = {1'b0, dmin, 1'b0};
      diag_d     = {1'b0, dmin, 1'b0} - {1'b0, dmaj, 1'b0};
      down_d     = minor_down;
    end else if (cmd_i.fire && busy_q) begin
      busy_d = !last;
      maj_d  = maj_t;
      min_d  = min_t;
      dec_d  = dec_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steep_q    <= steep_d;
    maj_q      <= maj_d;
    end_q      <= end_d;
    min_q      <= min_d;
    dec_q      <= dec_d;
    straight_q <= straight_d;
    diag_q     <= diag_d;
    down_q     <= down_d;
  end

endmodule
